FILE: rtl/source_code_tokenizer_defines.svh
// Assertion macros shared by the tokenizer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef SOURCE_CODE_TOKENIZER_DEFINES_SVH
`define SOURCE_CODE_TOKENIZER_DEFINES_SVH
`ifndef SYNTH
`define SCT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sct assertion failed");
`define SCT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("sct assertion failed");
`else
`define SCT_ASSERT(lbl, clk, rst_n, prop)
`define SCT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: rtl/sct_pkg.sv
// Types, token codes, character classes and keyword hash table for the tokenizer.
// No dependencies.
package sct_pkg;

  localparam int FIELD_W  = 24;
  localparam int KW_TABLE = 29;

  localparam logic [31:0] HASH_SEED = 32'hDEADBEEF;
  localparam logic [31:0] MUR_C1    = 32'hcc9e2d51;
  localparam logic [31:0] MUR_C2    = 32'h1b873593;
  localparam logic [31:0] MUR_C3    = 32'h85ebca6b;
  localparam logic [31:0] MUR_C4    = 32'hc2b2ae35;
  localparam logic [31:0] MUR_M5    = 32'd5;
  localparam logic [31:0] MUR_ADD   = 32'he6546b64;

  localparam logic [6:0] K_LPAREN = 7'd0,  K_RPAREN = 7'd1,  K_LBRACE = 7'd2;
  localparam logic [6:0] K_RBRACE = 7'd3,  K_LBRACK = 7'd4,  K_RBRACK = 7'd5;
  localparam logic [6:0] K_COMMA  = 7'd6,  K_DOT    = 7'd7,  K_SEMI   = 7'd8;
  localparam logic [6:0] K_TILDE  = 7'd9,  K_STAR   = 7'd10, K_STAR_EQ = 7'd11;
  localparam logic [6:0] K_MINUS  = 7'd12, K_ARROW  = 7'd13, K_DEC    = 7'd14;
  localparam logic [6:0] K_MINUS_EQ = 7'd15, K_PLUS = 7'd16, K_INC    = 7'd17;
  localparam logic [6:0] K_PLUS_EQ = 7'd18, K_COLON = 7'd19, K_SCOPE  = 7'd20;
  localparam logic [6:0] K_ASSIGN = 7'd21, K_PIPE   = 7'd22, K_OR     = 7'd23;
  localparam logic [6:0] K_AMP    = 7'd24, K_AND    = 7'd25, K_BANG   = 7'd26;
  localparam logic [6:0] K_NE     = 7'd27, K_EQ     = 7'd28, K_EQEQ   = 7'd29;
  localparam logic [6:0] K_LT     = 7'd30, K_LE     = 7'd31, K_GT     = 7'd32;
  localparam logic [6:0] K_GE     = 7'd33, K_SLASH  = 7'd34, K_SLASH_EQ = 7'd35;
  localparam logic [6:0] K_STRING = 7'd36, K_INTEGER = 7'd37, K_FLOAT = 7'd38;
  localparam logic [6:0] K_IDENT  = 7'd39, K_KW0    = 7'd40;

  localparam logic [1:0] E_NONE = 2'd0, E_CHAR = 2'd1, E_STR = 2'd2, E_CMT = 2'd3;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [6:0]         token_kind;
    logic [FIELD_W-1:0] start_offset;
    logic [FIELD_W-1:0] token_length;
    logic [FIELD_W-1:0] line_number;
    logic [FIELD_W-1:0] column_number;
    logic [1:0]         error_code;
    logic               run_end;
  } out_t;

  // hash engine request and response
  typedef struct packed {
    logic        start;
    logic        fin;
    logic        has_k;
    logic [31:0] h;
    logic [31:0] k;
    logic [31:0] len;
  } hcmd_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } hrsp_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] kind;
  } kind_hit_t;

  function automatic logic is_space(input logic [7:0] b);
    return b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0B || b == 8'h0C ||
           b == 8'h00 || b == 8'h0A;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_ident(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || b == "_";
  endfunction

  function automatic kind_hit_t single_kind(input logic [7:0] c);
    kind_hit_t r;
    r = '{hit: 1'b1, kind: K_LPAREN};
    unique case (c)
      "(": r.kind = K_LPAREN;
      ")": r.kind = K_RPAREN;
      "{": r.kind = K_LBRACE;
      "}": r.kind = K_RBRACE;
      "[": r.kind = K_LBRACK;
      "]": r.kind = K_RBRACK;
      ",": r.kind = K_COMMA;
      ".": r.kind = K_DOT;
      ";": r.kind = K_SEMI;
      "~": r.kind = K_TILDE;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic kind_hit_t starter_kind(input logic [7:0] c);
    kind_hit_t r;
    r = '{hit: 1'b1, kind: K_LPAREN};
    unique case (c)
      "*": r.kind = K_STAR;
      "-": r.kind = K_MINUS;
      "+": r.kind = K_PLUS;
      ":": r.kind = K_COLON;
      "|": r.kind = K_PIPE;
      "&": r.kind = K_AMP;
      "!": r.kind = K_BANG;
      "=": r.kind = K_EQ;
      "<": r.kind = K_LT;
      ">": r.kind = K_GT;
      "/": r.kind = K_SLASH;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic kind_hit_t pair_kind(input logic [7:0] c, input logic [7:0] d);
    kind_hit_t r;
    r = '{hit: 1'b0, kind: K_LPAREN};
    unique case (c)
      "*": if (d == "=") r = '{1'b1, K_STAR_EQ};
      "-": begin
        if (d == ">") r = '{1'b1, K_ARROW};
        else if (d == "-") r = '{1'b1, K_DEC};
        else if (d == "=") r = '{1'b1, K_MINUS_EQ};
      end
      "+": begin
        if (d == "+") r = '{1'b1, K_INC};
        else if (d == "=") r = '{1'b1, K_PLUS_EQ};
      end
      ":": begin
        if (d == ":") r = '{1'b1, K_SCOPE};
        else if (d == "=") r = '{1'b1, K_ASSIGN};
      end
      "|": if (d == "|") r = '{1'b1, K_OR};
      "&": if (d == "&") r = '{1'b1, K_AND};
      "!": if (d == "=") r = '{1'b1, K_NE};
      "=": if (d == "=") r = '{1'b1, K_EQEQ};
      "<": if (d == "=") r = '{1'b1, K_LE};
      ">": if (d == "=") r = '{1'b1, K_GE};
      "/": if (d == "=") r = '{1'b1, K_SLASH_EQ};
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // keyword text, right justified, zero padded
  localparam logic [47:0] KW_TXT [KW_TABLE] = '{
    "let", "var", "if", "else", "true", "false", "for", "in", "while", "nil",
    "extern", "return", "struct", "union", "enum", "u8", "u16", "u32", "u64",
    "i8", "i16", "i32", "i64", "f32", "f64", "char", "bool", "void", "ptr"
  };

  function automatic logic [31:0] mur_mix(input logic [31:0] k);
    logic [31:0] t;
    t = k * MUR_C1;
    t = {t[16:0], t[31:17]};
    return t * MUR_C2;
  endfunction

  function automatic logic [31:0] mur_fmix(input logic [31:0] h, input logic [31:0] len);
    logic [31:0] t;
    t = h ^ len;
    t = t ^ (t >> 16);
    t = t * MUR_C3;
    t = t ^ (t >> 13);
    t = t * MUR_C4;
    return t ^ (t >> 16);
  endfunction

  typedef logic [31:0] kw_tab_t [KW_TABLE];

  // elaboration-time hashes of the keyword texts
  function automatic kw_tab_t kw_table();
    kw_tab_t     tab;
    logic [31:0] h;
    logic [31:0] part;
    logic [47:0] txt;
    int          n;
    int          cnt;
    for (int i = 0; i < KW_TABLE; i++) begin
      txt  = KW_TXT[i];
      n    = 0;
      for (int j = 0; j < 6; j++) if (txt[8*j +: 8] != 8'h00) n = j + 1;
      h    = HASH_SEED;
      part = '0;
      cnt  = 0;
      for (int j = 0; j < n; j++) begin
        part = part | (32'(txt[8*(n-1-j) +: 8]) << (8*cnt));
        cnt  = cnt + 1;
        if (cnt == 4) begin
          h    = h ^ mur_mix(part);
          h    = {h[18:0], h[31:19]};
          h    = h * MUR_M5 + MUR_ADD;
          part = '0;
          cnt  = 0;
        end
      end
      if (cnt != 0) h = h ^ mur_mix(part);
      tab[i] = mur_fmix(h, 32'(n));
    end
    return tab;
  endfunction

  localparam kw_tab_t KW_HASH = kw_table();

endpackage

FILE: rtl/sct_murmur.sv
// Iterative MurmurHash3 x86_32 engine: block mix and finalization on one multiplier.
// Depends on sct_pkg and source_code_tokenizer_defines.svh.
`include "source_code_tokenizer_defines.svh"
module sct_murmur
  import sct_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  hcmd_t cmd,
  output hrsp_t rsp
);

  typedef enum logic [2:0] {
    H_IDLE, H_K1, H_K2, H_HMIX, H_HADD, H_F1, H_F2, H_F3
  } hstate_t;

  hstate_t     state_r, state_nxt;
  logic [31:0] h_r, h_nxt, p_r, p_nxt, len_r, len_nxt, res_r, res_nxt;
  logic        fin_r, fin_nxt, mixed_r, mixed_nxt, done_r, done_nxt;
  logic [31:0] mul_a, mul_b, prod, fx;

  // operand select for the shared multiplier
  always_comb begin
    fx    = (mixed_r ? (h_r ^ p_r) : h_r) ^ len_r;
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      H_K1:   begin mul_a = p_r; mul_b = MUR_C1; end
      H_K2:   begin mul_a = {p_r[16:0], p_r[31:17]}; mul_b = MUR_C2; end
      H_HMIX: begin mul_a = {h_r[18:0] ^ p_r[18:0], h_r[31:19] ^ p_r[31:19]}; mul_b = MUR_M5; end
      H_F1:   begin mul_a = fx ^ (fx >> 16); mul_b = MUR_C3; end
      H_F2:   begin mul_a = p_r ^ (p_r >> 13); mul_b = MUR_C4; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    state_nxt = state_r;
    h_nxt     = h_r;
    p_nxt     = p_r;
    len_nxt   = len_r;
    res_nxt   = res_r;
    fin_nxt   = fin_r;
    mixed_nxt = mixed_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      H_IDLE: if (cmd.start) begin
        h_nxt     = cmd.h;
        p_nxt     = cmd.k;
        len_nxt   = cmd.len;
        fin_nxt   = cmd.fin;
        mixed_nxt = cmd.has_k;
        state_nxt = (!cmd.fin || cmd.has_k) ? H_K1 : H_F1;
      end
      H_K1: begin p_nxt = prod; state_nxt = H_K2; end
      H_K2: begin p_nxt = prod; state_nxt = fin_r ? H_F1 : H_HMIX; end
      H_HMIX: begin p_nxt = prod; state_nxt = H_HADD; end
      H_HADD: begin
        res_nxt = p_r + MUR_ADD; done_nxt = 1'b1; state_nxt = H_IDLE;
      end
      H_F1: begin p_nxt = prod; state_nxt = H_F2; end
      H_F2: begin p_nxt = prod; state_nxt = H_F3; end
      H_F3: begin
        res_nxt = p_r ^ (p_r >> 16); done_nxt = 1'b1; state_nxt = H_IDLE;
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    h_r     <= h_nxt;
    p_r     <= p_nxt;
    len_r   <= len_nxt;
    res_r   <= res_nxt;
    fin_r   <= fin_nxt;
    mixed_r <= mixed_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

  `SCT_ASSERT(a_start_idle, clk, rst_n, cmd.start |-> (state_r == H_IDLE))
  `SCT_ASSERT_ALWAYS(a_done_pulse, clk, done_r |=> !done_r)
  `SCT_ASSERT(a_last_step_done, clk, rst_n, (state_r == H_HADD || state_r == H_F3) |=> done_r)

endmodule

FILE: rtl/source_code_tokenizer.sv
// Streaming source tokenizer top level: byte scanner, token staging and output register.
// Depends on sct_pkg, sct_murmur and source_code_tokenizer_defines.svh.
//
// Takes one source byte per transaction and emits up to three token transactions per
// byte, the last one flagged with run_end. Each byte walks a short sequencer (mode
// step, start-of-token step, end-of-text step, flush). Identifier bytes share one
// 32x32 multiplier in the hash engine: every fourth identifier byte adds a block mix,
// and the end of an identifier adds finalization plus the keyword match against the
// constant hash table. in_stall is high from the transaction until the sequencer is
// done with that byte; results wait in a one-deep staging register and the output
// register, so a stalled consumer holds the sequencer only when both are full. An
// error token ends the text; later bytes are dropped until a byte with final_byte
// set, which always restarts scanning on a new text.
`include "source_code_tokenizer_defines.svh"
module source_code_tokenizer
  import sct_pkg::*;
#(
  parameter int POSITION_BITS = 24,
  parameter int DEPTH_BITS    = 8,
  parameter int KEYWORD_COUNT = 29
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int PB  = POSITION_BITS;
  localparam int KWN = (KEYWORD_COUNT < KW_TABLE) ? KEYWORD_COUNT : KW_TABLE;
  localparam logic [6:0] K_EOF = 7'(int'(K_KW0) + KEYWORD_COUNT);

  typedef enum logic [3:0] {
    M_IDLE, M_OP, M_IDENT, M_INT, M_FRAC, M_STRING, M_LINE, M_BLOCK, M_HALT
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MODE, S_HWAIT, S_KW, S_START, S_FIN, S_FKW, S_EOF, S_FLUSH
  } state_t;

  state_t          state_r, state_nxt, ret_r, ret_nxt;
  mode_t           mode_r, mode_nxt;
  logic            used_r, used_nxt, fin_r, fin_nxt;
  logic [7:0]      b_r, b_nxt, pend_r, pend_nxt;
  logic [PB-1:0]   pos_r, pos_nxt, line_r, line_nxt, col_r, col_nxt;
  logic [PB-1:0]   tstart_r, tstart_nxt, tline_r, tline_nxt, tcol_r, tcol_nxt;
  logic [PB-1:0]   tlen_r, tlen_nxt;
  logic [DEPTH_BITS-1:0] depth_r, depth_nxt;
  logic [31:0]     hacc_r, hacc_nxt, part_r, part_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  out_t            stg_r, stg_nxt, out_r, out_nxt;
  logic            stg_v_r, stg_v_nxt, out_v_r, out_v_nxt;

  hcmd_t           hcmd;
  hrsp_t           hrsp;

  logic            emit_en, restart, hold;
  out_t            emit_d;

  sct_murmur u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (hcmd),
    .rsp   (hrsp)
  );

  function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
    return (v == '1) ? v : PB'(v + 1'b1);
  endfunction

  function automatic out_t mk(input logic [6:0] k, input logic [PB-1:0] s,
                              input logic [PB-1:0] l, input logic [PB-1:0] ln,
                              input logic [PB-1:0] cl, input logic [1:0] e);
    out_t r;
    r.token_kind    = k;
    r.start_offset  = FIELD_W'(s);
    r.token_length  = FIELD_W'(l);
    r.line_number   = FIELD_W'(ln);
    r.column_number = FIELD_W'(cl);
    r.error_code    = e;
    r.run_end       = 1'b0;
    return r;
  endfunction

  // first keyword whose full hash matches wins
  function automatic logic [6:0] kw_kind(input logic [31:0] h);
    logic [6:0] k;
    k = K_IDENT;
    for (int i = KWN - 1; i >= 0; i--) if (KW_HASH[i] == h) k = 7'(int'(K_KW0) + i);
    return k;
  endfunction

  // staged result can only move out when the output register frees up
  assign hold     = stg_v_r && out_v_r && out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    kind_hit_t   pk, sk, stk, bst;
    logic [31:0] part_new;
    logic        is_err;

    state_nxt  = state_r;
    ret_nxt    = ret_r;
    mode_nxt   = mode_r;
    used_nxt   = used_r;
    fin_nxt    = fin_r;
    b_nxt      = b_r;
    pend_nxt   = pend_r;
    pos_nxt    = pos_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    tstart_nxt = tstart_r;
    tline_nxt  = tline_r;
    tcol_nxt   = tcol_r;
    tlen_nxt   = tlen_r;
    depth_nxt  = depth_r;
    hacc_nxt   = hacc_r;
    part_nxt   = part_r;
    cnt_nxt    = cnt_r;
    stg_nxt    = stg_r;
    stg_v_nxt  = stg_v_r;
    out_nxt    = out_r;
    out_v_nxt  = out_v_r && out_stall;
    emit_en    = 1'b0;
    emit_d     = stg_r;
    restart    = 1'b0;
    hcmd       = '0;

    pk       = pair_kind(pend_r, b_r);
    stk      = starter_kind(pend_r);
    sk       = single_kind(b_r);
    bst      = starter_kind(b_r);
    part_new = part_r | (32'(b_r) << {cnt_r, 3'b000});
    is_err   = (mode_r == M_HALT) || (mode_r == M_STRING) || (mode_r == M_BLOCK);

    unique case (state_r)
      S_IDLE: if (in_valid) begin
        b_nxt     = in_data.source_byte;
        fin_nxt   = in_data.final_byte;
        state_nxt = S_MODE;
      end

      // continue the token in progress
      S_MODE: begin
        used_nxt  = 1'b0;
        state_nxt = S_START;
        unique case (mode_r)
          M_HALT: begin
            if (fin_r) restart = 1'b1;
            state_nxt = S_FLUSH;
          end
          M_OP: begin
            if (pk.hit) begin
              emit_en  = 1'b1;
              emit_d   = mk(pk.kind, tstart_r, '0, tline_r, tcol_r, E_NONE);
              mode_nxt = M_IDLE;
              used_nxt = 1'b1;
            end else if (pend_r == "/" && b_r == "*") begin
              mode_nxt  = M_BLOCK;
              depth_nxt = DEPTH_BITS'(1);
              pend_nxt  = '0;
              used_nxt  = 1'b1;
            end else if (pend_r == "/" && b_r == "/") begin
              mode_nxt = M_LINE;
              used_nxt = 1'b1;
            end else begin
              emit_en  = 1'b1;
              emit_d   = mk(stk.hit ? stk.kind : K_LPAREN, tstart_r, '0, tline_r, tcol_r,
                            E_NONE);
              mode_nxt = M_IDLE;
            end
          end
          M_IDENT: begin
            if (is_ident(b_r)) begin
              tlen_nxt = sat_inc(tlen_r);
              used_nxt = 1'b1;
              if (cnt_r == 2'd3) begin
                // full block: mix it into the accumulator
                hcmd.start = 1'b1;
                hcmd.h     = hacc_r;
                hcmd.k     = part_new;
                hcmd.has_k = 1'b1;
                part_nxt   = '0;
                cnt_nxt    = 2'd0;
                ret_nxt    = S_START;
                state_nxt  = S_HWAIT;
              end else begin
                part_nxt = part_new;
                cnt_nxt  = cnt_r + 2'd1;
              end
            end else begin
              hcmd.start = 1'b1;
              hcmd.fin   = 1'b1;
              hcmd.h     = hacc_r;
              hcmd.k     = part_r;
              hcmd.has_k = (cnt_r != 2'd0);
              hcmd.len   = 32'(tlen_r);
              mode_nxt   = M_IDLE;
              ret_nxt    = S_KW;
              state_nxt  = S_HWAIT;
            end
          end
          M_INT, M_FRAC: begin
            if (is_digit(b_r) || (mode_r == M_INT && b_r == ".")) begin
              if (b_r == ".") mode_nxt = M_FRAC;
              tlen_nxt = sat_inc(tlen_r);
              used_nxt = 1'b1;
            end else begin
              emit_en  = 1'b1;
              emit_d   = mk((mode_r == M_INT) ? K_INTEGER : K_FLOAT, tstart_r, tlen_r,
                            tline_r, tcol_r, E_NONE);
              mode_nxt = M_IDLE;
            end
          end
          M_STRING: begin
            used_nxt = 1'b1;
            if (b_r == "\"") begin
              emit_en  = 1'b1;
              emit_d   = mk(K_STRING, tstart_r, tlen_r, tline_r, tcol_r, E_NONE);
              mode_nxt = M_IDLE;
            end else begin
              tlen_nxt = sat_inc(tlen_r);
            end
          end
          M_LINE: begin
            if (b_r == 8'h0A) mode_nxt = M_IDLE;
            else used_nxt = 1'b1;
          end
          M_BLOCK: begin
            used_nxt = 1'b1;
            if (pend_r == "/" && b_r == "*") begin
              if (depth_r != '1) depth_nxt = depth_r + 1'b1;
              pend_nxt = '0;
            end else if (pend_r == "*" && b_r == "/") begin
              pend_nxt = '0;
              if (depth_r != '0) depth_nxt = depth_r - 1'b1;
              if (depth_r <= DEPTH_BITS'(1)) mode_nxt = M_IDLE;
            end else begin
              pend_nxt = b_r;
            end
          end
          default: mode_nxt = M_IDLE;
        endcase
      end

      S_HWAIT: if (hrsp.done) begin
        if (ret_r == S_START) hacc_nxt = hrsp.res;
        state_nxt = ret_r;
      end

      S_KW, S_FKW: if (!hold) begin
        emit_en   = 1'b1;
        emit_d    = mk(kw_kind(hrsp.res), tstart_r, tlen_r, tline_r, tcol_r, E_NONE);
        state_nxt = (state_r == S_KW) ? S_START : S_EOF;
      end

      // open a new token if the byte was not consumed, then advance the position
      S_START: if (!hold) begin
        if (!used_r && !is_space(b_r)) begin
          if (sk.hit) begin
            emit_en = 1'b1;
            emit_d  = mk(sk.kind, pos_r, '0, line_r, col_r, E_NONE);
          end else if (bst.hit) begin
            mode_nxt   = M_OP;
            pend_nxt   = b_r;
            tstart_nxt = pos_r;
            tline_nxt  = line_r;
            tcol_nxt   = col_r;
          end else if (b_r == "\"") begin
            mode_nxt   = M_STRING;
            tstart_nxt = sat_inc(pos_r);
            tline_nxt  = line_r;
            tcol_nxt   = col_r;
            tlen_nxt   = '0;
          end else if (is_alpha(b_r) || b_r == "_") begin
            mode_nxt   = M_IDENT;
            tstart_nxt = pos_r;
            tline_nxt  = line_r;
            tcol_nxt   = col_r;
            tlen_nxt   = PB'(1);
            hacc_nxt   = HASH_SEED;
            part_nxt   = 32'(b_r);
            cnt_nxt    = 2'd1;
          end else if (is_digit(b_r)) begin
            mode_nxt   = M_INT;
            tstart_nxt = pos_r;
            tline_nxt  = line_r;
            tcol_nxt   = col_r;
            tlen_nxt   = PB'(1);
          end else begin
            emit_en  = 1'b1;
            emit_d   = mk(K_EOF, pos_r, '0, line_r, col_r, E_CHAR);
            mode_nxt = M_HALT;
          end
        end
        if (b_r == 8'h0A) begin
          line_nxt = sat_inc(line_r);
          col_nxt  = PB'(1);
        end else begin
          col_nxt = sat_inc(col_r);
        end
        pos_nxt   = sat_inc(pos_r);
        state_nxt = S_FIN;
      end

      // end of text: close whatever is open
      S_FIN: begin
        if (!fin_r) begin
          state_nxt = S_FLUSH;
        end else if (!hold) begin
          state_nxt = S_EOF;
          unique case (mode_r)
            M_OP: begin
              emit_en = 1'b1;
              emit_d  = mk(stk.hit ? stk.kind : K_LPAREN, tstart_r, '0, tline_r, tcol_r,
                           E_NONE);
            end
            M_IDENT: begin
              hcmd.start = 1'b1;
              hcmd.fin   = 1'b1;
              hcmd.h     = hacc_r;
              hcmd.k     = part_r;
              hcmd.has_k = (cnt_r != 2'd0);
              hcmd.len   = 32'(tlen_r);
              ret_nxt    = S_FKW;
              state_nxt  = S_HWAIT;
            end
            M_INT, M_FRAC: begin
              emit_en = 1'b1;
              emit_d  = mk((mode_r == M_INT) ? K_INTEGER : K_FLOAT, tstart_r, tlen_r,
                           tline_r, tcol_r, E_NONE);
            end
            M_STRING: begin
              emit_en = 1'b1;
              emit_d  = mk(K_EOF, tstart_r, '0, tline_r, tcol_r, E_STR);
            end
            M_BLOCK: begin
              emit_en = 1'b1;
              emit_d  = mk(K_EOF, tstart_r, '0, tline_r, tcol_r, E_CMT);
            end
            default: state_nxt = S_EOF;
          endcase
        end
      end

      S_EOF: if (!hold) begin
        if (!is_err) begin
          emit_en = 1'b1;
          emit_d  = mk(K_EOF, pos_r, '0, line_r, col_r, E_NONE);
        end
        restart   = 1'b1;
        state_nxt = S_FLUSH;
      end

      // last result of this byte leaves with run_end set
      S_FLUSH: begin
        if (!stg_v_r) begin
          state_nxt = S_IDLE;
        end else if (!(out_v_r && out_stall)) begin
          out_nxt         = stg_r;
          out_nxt.run_end = 1'b1;
          out_v_nxt       = 1'b1;
          stg_v_nxt       = 1'b0;
          state_nxt       = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (emit_en) begin
      if (stg_v_r) begin
        out_nxt   = stg_r;
        out_v_nxt = 1'b1;
      end
      stg_nxt   = emit_d;
      stg_v_nxt = 1'b1;
    end

    if (restart) begin
      mode_nxt   = M_IDLE;
      pos_nxt    = '0;
      line_nxt   = PB'(1);
      col_nxt    = PB'(1);
      tstart_nxt = '0;
      tline_nxt  = PB'(1);
      tcol_nxt   = PB'(1);
      pend_nxt   = '0;
      depth_nxt  = '0;
      hacc_nxt   = HASH_SEED;
      part_nxt   = '0;
      cnt_nxt    = 2'd0;
      tlen_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_START;
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      line_r   <= PB'(1);
      col_r    <= PB'(1);
      tstart_r <= '0;
      tline_r  <= PB'(1);
      tcol_r   <= PB'(1);
      pend_r   <= '0;
      depth_r  <= '0;
      hacc_r   <= HASH_SEED;
      part_r   <= '0;
      cnt_r    <= 2'd0;
      tlen_r   <= '0;
      stg_v_r  <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      tstart_r <= tstart_nxt;
      tline_r  <= tline_nxt;
      tcol_r   <= tcol_nxt;
      pend_r   <= pend_nxt;
      depth_r  <= depth_nxt;
      hacc_r   <= hacc_nxt;
      part_r   <= part_nxt;
      cnt_r    <= cnt_nxt;
      tlen_r   <= tlen_nxt;
      stg_v_r  <= stg_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    used_r <= used_nxt;
    fin_r  <= fin_nxt;
    b_r    <= b_nxt;
    stg_r  <= stg_nxt;
    out_r  <= out_nxt;
  end

  `SCT_ASSERT(a_depth_open, clk, rst_n, (mode_r == M_BLOCK) |-> (depth_r != '0))
  `SCT_ASSERT(a_stage_no_overrun, clk, rst_n, (emit_en && stg_v_r) |-> !(out_v_r && out_stall))
  `SCT_ASSERT(a_eof_restart, clk, rst_n, (state_r == S_EOF && !hold) |=> (mode_r == M_IDLE && pos_r == '0))
  `SCT_ASSERT(a_hash_wait, clk, rst_n, hrsp.done |-> (state_r == S_HWAIT))

endmodule

FILE: tb/tb.sv
// Self-checking testbench for source_code_tokenizer: directed byte texts plus random
// token soup, predicted in-bench and compared per transaction. Depends on sct_pkg and source_code_tokenizer.
`timescale 1ns / 1ps
module tb;
  import sct_pkg::*;

  localparam int unsigned PMAX = 24'hFFFFFF;
  localparam int unsigned DMAX = 255;
  localparam logic [6:0]  K_END = 7'd69;
  localparam int unsigned CYCLE_LIMIT = 600000;

  // scanner modes of the predictor
  typedef enum int {S_IDLE, S_OP, S_IDENT, S_INT, S_FRAC, S_STR, S_LINE, S_BLOCK, S_HALT} scan_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  source_code_tokenizer i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  scan_t       mode;
  int unsigned pos, line, col, tstart, tline, tcol, tlen, depth, tail;
  logic [7:0]  pend;
  logic [31:0] hacc, hpart;
  logic [31:0] kw_hash [KW_TABLE];

  in_t  byte_q [$];
  out_t token_q [$];
  int   errors = 0;
  int   tokens_seen = 0;
  int   texts = 0;
  bit   calm = 1'b0;        // no idling stretch
  bit   drain_hold = 1'b0;  // long receiver hold-off
  bit   in_taken = 1'b0;    // current input transaction was accepted
  int unsigned cycles = 0;

  function automatic int unsigned inc(int unsigned v);
    return v < PMAX ? v + 1 : PMAX;
  endfunction

  function automatic logic [31:0] rl(logic [31:0] x, int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] blk(logic [31:0] k);
    return rl(k * 32'hcc9e2d51, 15) * 32'h1b873593;
  endfunction

  function automatic logic [31:0] fold(logic [31:0] h, logic [31:0] p, int unsigned c,
                                       int unsigned n);
    if (c != 0) h ^= blk(p);
    h ^= n;
    h ^= h >> 16; h *= 32'h85ebca6b;
    h ^= h >> 13; h *= 32'hc2b2ae35;
    h ^= h >> 16;
    return h;
  endfunction

  task automatic absorb(input logic [7:0] b);
    hpart |= 32'(b) << (8 * tail);
    tail++;
    if (tail == 4) begin
      hacc ^= blk(hpart);
      hacc = rl(hacc, 13) * 5 + 32'he6546b64;
      hpart = 0;
      tail = 0;
    end
  endtask

  task automatic fresh_text();
    mode = S_IDLE; pos = 0; line = 1; col = 1; tstart = 0; tline = 1; tcol = 1;
    pend = 0; depth = 0; hacc = HASH_SEED; hpart = 0; tail = 0; tlen = 0;
  endtask

  task automatic build_keywords();
    string kw [KW_TABLE] = '{"let", "var", "if", "else", "true", "false", "for", "in",
      "while", "nil", "extern", "return", "struct", "union", "enum", "u8", "u16", "u32",
      "u64", "i8", "i16", "i32", "i64", "f32", "f64", "char", "bool", "void", "ptr"};
    for (int i = 0; i < KW_TABLE; i++) begin
      hacc = HASH_SEED; hpart = 0; tail = 0;
      for (int j = 0; j < kw[i].len(); j++) absorb(kw[i][j]);
      kw_hash[i] = fold(hacc, hpart, tail, kw[i].len());
    end
  endtask

  function automatic int single_code(logic [7:0] c);
    case (c)
      "(": return K_LPAREN; ")": return K_RPAREN; "{": return K_LBRACE;
      "}": return K_RBRACE; "[": return K_LBRACK; "]": return K_RBRACK;
      ",": return K_COMMA;  ".": return K_DOT;    ";": return K_SEMI;
      "~": return K_TILDE;
      default: return -1;
    endcase
  endfunction

  function automatic int lead_code(logic [7:0] c);
    case (c)
      "*": return K_STAR;  "-": return K_MINUS; "+": return K_PLUS; ":": return K_COLON;
      "|": return K_PIPE;  "&": return K_AMP;   "!": return K_BANG; "=": return K_EQ;
      "<": return K_LT;    ">": return K_GT;    "/": return K_SLASH;
      default: return -1;
    endcase
  endfunction

  function automatic int pair_code(logic [7:0] c, logic [7:0] d);
    case (c)
      "*": return d == "=" ? K_STAR_EQ : -1;
      "-": return d == ">" ? K_ARROW : d == "-" ? K_DEC : d == "=" ? K_MINUS_EQ : -1;
      "+": return d == "+" ? K_INC : d == "=" ? K_PLUS_EQ : -1;
      ":": return d == ":" ? K_SCOPE : d == "=" ? K_ASSIGN : -1;
      "|": return d == "|" ? K_OR : -1;
      "&": return d == "&" ? K_AND : -1;
      "!": return d == "=" ? K_NE : -1;
      "=": return d == "=" ? K_EQEQ : -1;
      "<": return d == "=" ? K_LE : -1;
      ">": return d == "=" ? K_GE : -1;
      "/": return d == "=" ? K_SLASH_EQ : -1;
      default: return -1;
    endcase
  endfunction

  function automatic bit digit(logic [7:0] b); return b >= "0" && b <= "9"; endfunction
  function automatic bit alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  task automatic push_tok(ref out_t run [$], input int kind, int unsigned st,
                          int unsigned ln, int unsigned li, int unsigned co, logic [1:0] e);
    out_t t;
    t.token_kind = 7'(kind); t.start_offset = st[23:0]; t.token_length = ln[23:0];
    t.line_number = li[23:0]; t.column_number = co[23:0]; t.error_code = e;
    t.run_end = 1'b0;
    run.push_back(t);
  endtask

  task automatic ident_tok(ref out_t run [$]);
    logic [31:0] h;
    int kind;
    h = fold(hacc, hpart, tail, tlen);
    kind = K_IDENT;
    for (int i = 0; i < KW_TABLE; i++)
      if (kw_hash[i] == h) begin
        kind = K_KW0 + i;
        break;
      end
    push_tok(run, kind, tstart, tlen, tline, tcol, E_NONE);
  endtask

  task automatic open_tok(int unsigned st);
    tstart = st; tline = line; tcol = col;
  endtask

  // Predict the tokens one accepted byte produces and queue them.
  task automatic predict_tokens(input in_t it);
    out_t run [$];
    logic [7:0] b;
    bit used, err;
    int k;
    b = it.source_byte;
    used = 0;
    if (mode == S_HALT) begin
      if (it.final_byte) fresh_text();
      return;
    end
    case (mode)
      S_OP: begin
        k = pair_code(pend, b);
        if (k >= 0) begin
          push_tok(run, k, tstart, 0, tline, tcol, E_NONE); mode = S_IDLE; used = 1;
        end else if (pend == "/" && b == "*") begin
          mode = S_BLOCK; depth = 1; pend = 0; used = 1;
        end else if (pend == "/" && b == "/") begin
          mode = S_LINE; used = 1;
        end else begin
          push_tok(run, lead_code(pend), tstart, 0, tline, tcol, E_NONE); mode = S_IDLE;
        end
      end
      S_IDENT:
        if (alpha(b) || digit(b)) begin
          absorb(b); tlen = inc(tlen); used = 1;
        end else begin
          ident_tok(run); mode = S_IDLE;
        end
      S_INT, S_FRAC:
        if (digit(b) || (mode == S_INT && b == ".")) begin
          if (b == ".") mode = S_FRAC;
          tlen = inc(tlen); used = 1;
        end else begin
          push_tok(run, mode == S_INT ? K_INTEGER : K_FLOAT, tstart, tlen, tline, tcol,
                   E_NONE);
          mode = S_IDLE;
        end
      S_STR: begin
        used = 1;
        if (b == "\"") begin
          push_tok(run, K_STRING, tstart, tlen, tline, tcol, E_NONE); mode = S_IDLE;
        end else tlen = inc(tlen);
      end
      S_LINE: if (b == 8'h0A) mode = S_IDLE; else used = 1;
      S_BLOCK: begin
        used = 1;
        if (pend == "/" && b == "*") begin
          if (depth < DMAX) depth++;
          pend = 0;
        end else if (pend == "*" && b == "/") begin
          if (depth > 0) depth--;
          pend = 0;
          if (depth == 0) mode = S_IDLE;
        end else pend = b;
      end
      default: mode = S_IDLE;
    endcase
    if (!used && !(b inside {" ", 8'h09, 8'h0D, 8'h0B, 8'h0C, 8'h00, 8'h0A})) begin
      if (single_code(b) >= 0) push_tok(run, single_code(b), pos, 0, line, col, E_NONE);
      else if (lead_code(b) >= 0) begin
        mode = S_OP; pend = b; open_tok(pos);
      end else if (b == "\"") begin
        mode = S_STR; open_tok(inc(pos)); tlen = 0;
      end else if (alpha(b)) begin
        mode = S_IDENT; open_tok(pos); tlen = 1;
        hacc = HASH_SEED; hpart = 0; tail = 0; absorb(b);
      end else if (digit(b)) begin
        mode = S_INT; open_tok(pos); tlen = 1;
      end else begin
        push_tok(run, K_END, pos, 0, line, col, E_CHAR); mode = S_HALT;
      end
    end
    if (b == 8'h0A) begin
      line = inc(line); col = 1;
    end else col = inc(col);
    pos = inc(pos);
    if (it.final_byte) begin
      err = mode == S_HALT;
      case (mode)
        S_OP:    push_tok(run, lead_code(pend), tstart, 0, tline, tcol, E_NONE);
        S_IDENT: ident_tok(run);
        S_INT:   push_tok(run, K_INTEGER, tstart, tlen, tline, tcol, E_NONE);
        S_FRAC:  push_tok(run, K_FLOAT, tstart, tlen, tline, tcol, E_NONE);
        S_STR: begin push_tok(run, K_END, tstart, 0, tline, tcol, E_STR); err = 1; end
        S_BLOCK: begin push_tok(run, K_END, tstart, 0, tline, tcol, E_CMT); err = 1; end
        default: ;
      endcase
      if (!err) push_tok(run, K_END, pos, 0, line, col, E_NONE);
      fresh_text();
    end
    if (run.size() > 0) run[$].run_end = 1'b1;
    foreach (run[i]) token_q.push_back(run[i]);
  endtask

  // Driver: change inputs at the falling edge; predict at the accepting rising edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predict_tokens(in_data);
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        in_taken = 1'b0;
        if (byte_q.size() > 0 && (calm || $urandom_range(99) >= 38)) begin
          in_data <= byte_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= drain_hold || (!calm && $urandom_range(99) < 38);
    end
  end

  // Monitor: compare each accepted token transaction with the oldest prediction.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      tokens_seen <= tokens_seen + 1;
      if (token_q.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected token transaction %p", out_data);
      end else begin
        out_t want;
        want = token_q.pop_front();
        if (want !== out_data) begin
          errors <= errors + 1;
          if (errors < 10) $display("token mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_text(input string s, input bit fin_last);
    in_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.source_byte = s[i];
      it.final_byte = fin_last && i == s.len() - 1;
      byte_q.push_back(it);
    end
    if (fin_last) texts++;
  endtask

  function automatic string rand_piece();
    string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string ops [] = '{"(", ")", "{", "}", "[", "]", ",", ".", ";", "~", "*", "*=", "-",
      "->", "--", "-=", "+", "++", "+=", ":", "::", ":=", "|", "||", "&", "&&", "!",
      "!=", "=", "==", "<", "<=", ">", ">=", "/", "/="};
    string kws [] = '{"let", "while", "return", "struct", "u64", "f32", "ptr", "void"};
    string s;
    int n;
    int c;
    s = "";
    case ($urandom_range(9))
      0, 1: begin
        s = "a"; s[0] = alnum[$urandom_range(52)];
        n = $urandom_range(9);
        for (int i = 0; i < n; i++) begin
          c = $urandom_range(62);
          s = {s, alnum.substr(c, c)};
        end
        s = {s.substr(0, 0), s.substr(1, s.len() - 1)};
      end
      2: s = kws[$urandom_range(kws.size() - 1)];
      3: begin
        n = $urandom_range(5) + 1;
        for (int i = 0; i < n; i++) begin
          s = {s, "0"};
          s[i] = 8'("0" + $urandom_range(9));
        end
        if ($urandom_range(1)) s = {s, ".5"};
      end
      4: s = ops[$urandom_range(ops.size() - 1)];
      5: s = {"\"str", $urandom_range(1) ? "\n" : " ", "x\""};
      6: s = $urandom_range(1) ? "// note\n" : "/* a /* b **/ c */";
      7: s = $urandom_range(1) ? " " : "\n\t";
      default: begin
        s = "x";
        s[0] = 8'($urandom_range(255));
        if (s[0] == 8'h00) s = " ";
      end
    endcase
    return s;
  endfunction

  initial begin
    int bytes;
    fresh_text();
    build_keywords();
    fresh_text();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed texts: operators, literals, keywords, comments and each error kind
    add_text("let x1 = 42; y := 3.14 -> a::b", 1);
    add_text("(){}[],.;~ *= -- -= ++ += || && != == <= >= /= * - + | & ! < > : = /", 1);
    add_text("\"hi\nthere\" /* one /* two ***/ x */ // skip\nf64 ptr", 1);
    add_text("abc $ ignored", 0);
    add_text("tail", 1);
    add_text("\"open", 1);
    add_text("/* never closed", 1);
    add_text("\x00\x7f\xff", 1);
    add_text("-", 1);
    add_text("9.", 1);

    // random texts; hold the receiver off for a long stretch early on
    bytes = 0;
    while (bytes < 130) begin
      string t;
      int n;
      t = "";
      n = $urandom_range(12) + 1;
      for (int i = 0; i < n; i++) t = {t, rand_piece(), $urandom_range(2) ? " " : ""};
      bytes += t.len();
      add_text(t, $urandom_range(4) != 0 || bytes >= 130);
    end

    fork
      begin
        wait (byte_q.size() < 500);
        drain_hold = 1'b1;
        repeat (400) @(posedge clk);
        drain_hold = 1'b0;
      end
      begin
        wait (byte_q.size() < 300);
        calm = 1'b1;
        repeat (600) @(posedge clk);
        calm = 1'b0;
      end
    join

    wait (byte_q.size() == 0 && !in_valid);
    wait (token_q.size() == 0);
    repeat (100) @(posedge clk);
    $display("Covered %0d texts, %0d token transactions checked, %0d mismatches.",
             texts, tokens_seen, errors);
    if (errors == 0 && token_q.size() == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
